// ----- hw/rtl/scld_pkg.sv -----
package scld_pkg;

  // Longest body any command can buffer (CAN limit plus one) fits well below this.
  localparam int BODY_DEPTH = 32;
  localparam int LEN_W      = $clog2(BODY_DEPTH + 1);

  // Result kinds
  localparam logic [2:0] KIND_AREAD  = 3'd0;
  localparam logic [2:0] KIND_AWRITE = 3'd1;
  localparam logic [2:0] KIND_DREAD  = 3'd2;
  localparam logic [2:0] KIND_DWRITE = 3'd3;
  localparam logic [2:0] KIND_CAN    = 3'd4;

  // Pin letter codes
  localparam logic [2:0] PIN_A = 3'd0;
  localparam logic [2:0] PIN_B = 3'd1;
  localparam logic [2:0] PIN_D = 3'd2;
  localparam logic [2:0] PIN_E = 3'd3;
  localparam logic [2:0] PIN_P = 3'd4;
  localparam logic [2:0] PIN_Q = 3'd5;

  // Characters
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LM    = 8'h6D;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LQ    = 8'h71;

  // Body length limits per command
  localparam logic [LEN_W-1:0] LIM_AREAD  = LEN_W'(2);
  localparam logic [LEN_W-1:0] LIM_AWRITE = LEN_W'(5);
  localparam logic [LEN_W-1:0] LIM_DREAD  = LEN_W'(2);
  localparam logic [LEN_W-1:0] LIM_DWRITE = LEN_W'(3);
  localparam logic [LEN_W-1:0] LIM_CAN    = LEN_W'(27);

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [2:0]  pin_kind;
    logic [3:0]  pwm_channel;
    logic [6:0]  duty;
    logic        level;
    logic [11:0] can_id;
    logic [3:0]  can_count;
    logic [63:0] can_payload;
  } result_t;

  function automatic logic [LEN_W-1:0] body_limit(input logic [2:0] k);
    logic [LEN_W-1:0] lim;
    unique case (k)
      KIND_AREAD:  lim = LIM_AREAD;
      KIND_AWRITE: lim = LIM_AWRITE;
      KIND_DREAD:  lim = LIM_DREAD;
      KIND_DWRITE: lim = LIM_DWRITE;
      KIND_CAN:    lim = LIM_CAN;
      default:     lim = '0;
    endcase
    return lim;
  endfunction

  // Bit 4 set: not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    logic [4:0] v;
    t = '0;
    v = 5'h10;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
      v = {1'b0, t[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + 8'd10;
      v = {1'b0, t[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + 8'd10;
      v = {1'b0, t[3:0]};
    end
    return v;
  endfunction

  // Bit 3 set: valid pin letter.
  function automatic logic [3:0] pin_code(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      CH_LA:   r = {1'b1, PIN_A};
      CH_LB:   r = {1'b1, PIN_B};
      CH_LD:   r = {1'b1, PIN_D};
      CH_LE:   r = {1'b1, PIN_E};
      CH_LP:   r = {1'b1, PIN_P};
      CH_LQ:   r = {1'b1, PIN_Q};
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/scld_body_tracker.sv -----
module scld_body_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        ch,
  output logic              fire,
  output scld_pkg::result_t res
);
  import scld_pkg::*;

  logic             in_body;
  logic [2:0]       cur_kind;
  logic [LEN_W-1:0] body_len;
  logic [1:0]       phase;      // body_len mod 3

  // Per-position fields, filled as characters arrive
  logic [3:0]  slot_v;
  logic        slot_ok;
  logic [2:0]  pin_v;
  logic        pin_ok;
  logic [3:0]  chan;
  logic        chan_ok;
  logic        level;
  logic        level_ok;
  logic [6:0]  tens;
  logic [6:0]  duty;
  logic        duty_ok;
  logic        can_ok;
  logic [11:0] can_id;
  logic [3:0]  hi_nib;
  logic [3:0]  can_count;
  logic [63:0] payload;

  logic [4:0] hexv;
  logic       is_hex;
  logic       is_dig;
  logic [7:0] dig_full;
  logic [3:0] dig;
  logic [3:0] pin_r;
  logic       is_cmd;
  logic [2:0] cmd_kind;
  logic       is_semi;
  logic       over;
  logic       pin_good;
  logic       body_ok;

  always_comb begin
    hexv     = hex_val(ch);
    is_hex   = ~hexv[4];
    is_dig   = (ch >= CH_0) && (ch <= CH_9);
    dig_full = ch - CH_0;
    dig      = dig_full[3:0];
    pin_r    = pin_code(ch);
    is_semi  = (ch == CH_SEMI);
    is_cmd   = 1'b1;
    cmd_kind = KIND_AREAD;
    unique case (ch)
      CH_LA:   cmd_kind = KIND_AREAD;
      CH_LB:   cmd_kind = KIND_AWRITE;
      CH_LD:   cmd_kind = KIND_DREAD;
      CH_LE:   cmd_kind = KIND_DWRITE;
      CH_LM:   cmd_kind = KIND_CAN;
      default: is_cmd = 1'b0;
    endcase
    over = (body_len > body_limit(cur_kind)) || (body_len >= LEN_W'(BODY_DEPTH));
  end

  always_comb begin
    pin_good = slot_ok && pin_ok;
    unique case (cur_kind)
      KIND_AREAD, KIND_DREAD: body_ok = (body_len == LEN_W'(2)) && pin_good;
      KIND_AWRITE: body_ok = (body_len == LEN_W'(5)) && chan_ok && duty_ok && pin_good;
      KIND_DWRITE: body_ok = (body_len == LEN_W'(3)) && level_ok && pin_good;
      KIND_CAN:    body_ok = can_ok && (phase == 2'd0) && (body_len >= LEN_W'(3))
                             && (body_len <= LIM_CAN);
      default:     body_ok = 1'b0;
    endcase
    fire = step && in_body && is_semi && body_ok;
  end

  // Fields outside the result's kind read as zero.
  always_comb begin
    res      = '0;
    res.kind = cur_kind;
    if (cur_kind != KIND_CAN) begin
      res.slot     = slot_v;
      res.pin_kind = pin_v;
    end
    if (cur_kind == KIND_AWRITE) begin
      res.pwm_channel = chan;
      res.duty        = duty;
    end
    if (cur_kind == KIND_DWRITE) begin
      res.level = level;
    end
    if (cur_kind == KIND_CAN) begin
      res.can_id      = can_id;
      res.can_count   = can_count;
      res.can_payload = payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body  <= 1'b0;
      cur_kind <= KIND_AREAD;
      body_len <= '0;
      phase    <= 2'd0;
    end else if (step) begin
      if (!in_body) begin
        if (is_cmd) begin
          in_body   <= 1'b1;
          cur_kind  <= cmd_kind;
          body_len  <= '0;
          phase     <= 2'd0;
          can_ok    <= 1'b1;
          can_count <= 4'd0;
          payload   <= '0;
        end
      end else if (is_semi || over) begin
        in_body <= 1'b0;
      end else begin
        body_len <= body_len + LEN_W'(1);
        phase    <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;

        unique case (body_len)
          LEN_W'(0): begin
            slot_v  <= dig;
            slot_ok <= is_dig;
          end
          LEN_W'(1): begin
            pin_v  <= pin_r[2:0];
            pin_ok <= pin_r[3];
          end
          LEN_W'(2): begin
            chan     <= dig;
            chan_ok  <= (ch >= CH_0) && (ch <= CH_8);
            level    <= (ch == CH_1);
            level_ok <= (ch == CH_0) || (ch == CH_1);
          end
          LEN_W'(3): begin
            tens    <= {dig, 3'b000} + 7'({dig, 1'b0});
            duty_ok <= is_dig;
          end
          LEN_W'(4): begin
            duty    <= tens + 7'(dig);
            duty_ok <= duty_ok && is_dig;
          end
          default: ;
        endcase

        // CAN: hex at the ID and in byte pairs, comma at each later third place
        if (body_len != '0 && phase == 2'd0) begin
          can_ok <= can_ok && (ch == CH_COMMA);
        end else begin
          can_ok <= can_ok && is_hex;
        end
        if (body_len < LEN_W'(3)) begin
          can_id <= {can_id[7:0], hexv[3:0]};
        end
        if (body_len >= LEN_W'(4) && phase == 2'd1) begin
          hi_nib <= hexv[3:0];
        end
        if (body_len >= LEN_W'(5) && phase == 2'd2 && !can_count[3]) begin
          payload[{can_count[2:0], 3'b000} +: 8] <= {hi_nib, hexv[3:0]};
          can_count <= can_count + 4'd1;
        end
      end
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    in_body |-> body_len <= LIM_CAN + LEN_W'(1))
    else $error("body length past largest limit");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> !in_body)
    else $error("still in body after a result");

  a_can_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_body && cur_kind == KIND_CAN |-> can_count <= 4'd8)
    else $error("CAN byte count past eight");

endmodule

// ----- hw/rtl/serial_command_line_decoder_unit.sv -----
// Serial command line decoder: one ASCII character per beat in, at most one decoded
// command per terminating ';' out.
// A ';' is first held in the input register; its result is then registered in the output register.
// Throughput: one character per cycle; input stalls only when a result is held unread.
// Reset (rst, synchronous, active high): back to waiting for a command letter,
// input and output stages empty.
module serial_command_line_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [3:0]  slot,
  output logic [2:0]  pin_kind,
  output logic [3:0]  pwm_channel,
  output logic [6:0]  duty,
  output logic        level,
  output logic [11:0] can_id,
  output logic [3:0]  can_count,
  output logic [63:0] can_payload
);
  import scld_pkg::*;

  // Input register
  logic       s1_valid;
  logic [7:0] ch_q;

  // Result register
  result_t res_q;
  result_t res;
  logic    fire;

  logic out_free;
  logic step;

  // The output register frees up when empty or being read this cycle; the input
  // stage moves on into the tracker only then, so a result is never overwritten.
  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Character tracker: body state and incremental field decode
  scld_body_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (ch_q),
    .fire (fire),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_q <= ch;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign kind        = res_q.kind;
  assign slot        = res_q.slot;
  assign pin_kind    = res_q.pin_kind;
  assign pwm_channel = res_q.pwm_channel;
  assign duty        = res_q.duty;
  assign level       = res_q.level;
  assign can_id      = res_q.can_id;
  assign can_count   = res_q.can_count;
  assign can_payload = res_q.can_payload;

  a_hold_input_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |=> s1_valid && $stable(ch_q))
    else $error("input stage moved while result stalled");

  a_fire_needs_room: assert property (@(posedge clk) disable iff (rst)
    fire |-> out_free && s1_valid)
    else $error("result produced with no room in output register");

  a_out_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_CAN)
    else $error("result kind out of range");

endmodule

// ----- verif/serial_command_line_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module serial_command_line_decoder_unit_tb;
  import scld_pkg::*;

  localparam int N_ITEMS      = 1850;  // input beats over the whole run
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off

  // Clock, reset and DUT ports; every input known from time zero.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ch = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  slot;
  logic [2:0]  pin_kind;
  logic [3:0]  pwm_channel;
  logic [6:0]  duty;
  logic        level;
  logic [11:0] can_id;
  logic [3:0]  can_count;
  logic [63:0] can_payload;

  always #4 clk = ~clk;

  serial_command_line_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .slot(slot), .pin_kind(pin_kind), .pwm_channel(pwm_channel),
    .duty(duty), .level(level), .can_id(can_id), .can_count(can_count),
    .can_payload(can_payload)
  );

  // Decoder state as the predictor sees it
  bit          cmd_open = 1'b0;
  logic [2:0]  cmd_kind = KIND_AREAD;
  int unsigned body_len = 0;
  logic [7:0]  body_buf [BODY_DEPTH] = '{default: 8'h00};

  result_t pending_cmds [$];   // decoded commands still owed by the DUT
  int      n_err = 0;
  int      items_taken = 0;    // input beats accepted
  bit      typed_row = 1'b0;   // directed row carries its own expectation
  bit      idle_en = 1'b1;
  bit      hold_req = 1'b0;

  logic [7:0] cmd_letter [5] = '{CH_LA, CH_LB, CH_LD, CH_LE, CH_LM};
  logic [7:0] pin_letter [6] = '{CH_LA, CH_LB, CH_LD, CH_LE, CH_LP, CH_LQ};

  // Directed table
  string   dir_text [$];
  bit      dir_typed [$];
  bit      dir_has [$];
  result_t dir_res [$];

  logic [7:0] line_buf [$];

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned max_body(input logic [2:0] k);
    case (k)
      KIND_AREAD:  return 2;
      KIND_AWRITE: return 5;
      KIND_DREAD:  return 2;
      KIND_DWRITE: return 3;
      default:     return 27;
    endcase
  endfunction

  // -1 when not a hex digit
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    return -1;
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic int pin_index(input logic [7:0] c);
    case (c)
      CH_LA:   return PIN_A;
      CH_LB:   return PIN_B;
      CH_LD:   return PIN_D;
      CH_LE:   return PIN_E;
      CH_LP:   return PIN_P;
      CH_LQ:   return PIN_Q;
      default: return -1;
    endcase
  endfunction

  // Checks the buffered body on ';' and builds the command it encodes.
  function automatic bit decode_line(output result_t r);
    bit          pin_ok;
    bit          ok;
    int          nib;
    int unsigned cnt;
    logic [63:0] pay;
    r = '0;
    r.kind = cmd_kind;
    pin_ok = is_dec(body_buf[0]) && pin_index(body_buf[1]) >= 0;
    if (pin_ok && cmd_kind != KIND_CAN) begin
      r.slot     = 4'(body_buf[0] - CH_0);
      r.pin_kind = 3'(pin_index(body_buf[1]));
    end
    ok = 1'b0;
    case (cmd_kind)
      KIND_AREAD, KIND_DREAD: ok = body_len == 2 && pin_ok;
      KIND_AWRITE: begin
        ok = body_len == 5 && pin_ok && body_buf[2] >= CH_0 && body_buf[2] <= CH_8 &&
             is_dec(body_buf[3]) && is_dec(body_buf[4]);
        r.pwm_channel = 4'(body_buf[2] - CH_0);
        r.duty = 7'((body_buf[3] - CH_0) * 10 + (body_buf[4] - CH_0));
      end
      KIND_DWRITE: begin
        ok = body_len == 3 && pin_ok && (body_buf[2] == CH_0 || body_buf[2] == CH_1);
        r.level = body_buf[2] == CH_1;
      end
      KIND_CAN: begin
        // id digits, then ",hh" per byte
        ok = body_len >= 3 && body_len % 3 == 0 && body_len <= 27;
        for (int i = 0; i < body_len; i++) begin
          if (i == 0 || i % 3 != 0) begin
            if (hex_nibble(body_buf[i]) < 0) ok = 1'b0;
          end else if (body_buf[i] != CH_COMMA) begin
            ok = 1'b0;
          end
        end
        if (ok) begin
          cnt = 0;
          pay = '0;
          for (int i = 4; i + 1 < body_len; i += 3) begin
            nib = hex_nibble(body_buf[i]) * 16 + hex_nibble(body_buf[i + 1]);
            pay |= 64'(nib) << (8 * cnt);
            cnt++;
          end
          r.can_id = 12'(hex_nibble(body_buf[0]) * 256 + hex_nibble(body_buf[1]) * 16 +
                         hex_nibble(body_buf[2]));
          r.can_count = 4'(cnt);
          r.can_payload = pay;
        end
      end
      default: ok = 1'b0;
    endcase
    if (!ok) r = '0;
    return ok;
  endfunction

  // One accepted character: updates state; got is set when a command completes.
  function automatic void take_char(input logic [7:0] c, output bit got,
                                    output result_t r);
    bit took;
    took = 1'b1;
    got = 1'b0;
    r = '0;
    if (!cmd_open) begin
      case (c)
        CH_LA:   cmd_kind = KIND_AREAD;
        CH_LB:   cmd_kind = KIND_AWRITE;
        CH_LD:   cmd_kind = KIND_DREAD;
        CH_LE:   cmd_kind = KIND_DWRITE;
        CH_LM:   cmd_kind = KIND_CAN;
        default: took = 1'b0;
      endcase
      if (took) begin
        cmd_open = 1'b1;
        body_len = 0;
      end
    end else if (c == CH_SEMI) begin
      cmd_open = 1'b0;
      got = decode_line(r);
    end else if (body_len > max_body(cmd_kind) || body_len >= BODY_DEPTH) begin
      cmd_open = 1'b0;  // overflow: command dropped
    end else begin
      body_buf[body_len] = c;
      body_len++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: input beats feed the predictor, output beats are checked
  // ---------------------------------------------------------------------------
  function automatic void cmp(input string name, input logic [63:0] want,
                              input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin : mon
    bit      got;
    result_t r;
    result_t e;
    if (!rst) begin
      if (in_valid && in_ready) begin
        take_char(ch, got, r);
        items_taken++;
        if (got && !typed_row) pending_cmds.push_back(r);
      end
      if (out_valid && out_ready) begin
        if (pending_cmds.size() == 0) begin
          $error("unexpected result beat, kind %0d", kind);
          n_err++;
        end else begin
          e = pending_cmds.pop_front();
          cmp("kind", e.kind, kind);
          cmp("slot", e.slot, slot);
          cmp("pin_kind", e.pin_kind, pin_kind);
          cmp("pwm_channel", e.pwm_channel, pwm_channel);
          cmp("duty", e.duty, duty);
          cmp("level", e.level, level);
          cmp("can_id", e.can_id, can_id);
          cmp("can_count", e.can_count, can_count);
          cmp("can_payload", e.can_payload, can_payload);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Drives one beat from a falling edge, with random gaps, and returns right
  // after the rising edge that accepts it. Valid is left high on return.
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every owed command has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(CH_0 + v);
    return 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 10);
  endfunction

  // Builds one random line: mostly well-formed commands with random content,
  // some malformed bodies, some idle noise.
  function automatic void make_line();
    int r;
    int k;
    int n;
    line_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      k = $urandom_range(0, 4);
      line_buf.push_back(cmd_letter[k]);
      if (k == KIND_CAN) begin
        repeat (3) line_buf.push_back(rand_hex_char());
        n = $urandom_range(0, 8);
        repeat (n) begin
          line_buf.push_back(CH_COMMA);
          line_buf.push_back(rand_hex_char());
          line_buf.push_back(rand_hex_char());
        end
      end else begin
        line_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
        line_buf.push_back(pin_letter[$urandom_range(0, 5)]);
        if (k == KIND_AWRITE) begin
          line_buf.push_back(8'(CH_0 + $urandom_range(0, 8)));
          line_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
          line_buf.push_back(8'(CH_0 + $urandom_range(0, 9)));
        end else if (k == KIND_DWRITE) begin
          line_buf.push_back(8'(CH_0 + $urandom_range(0, 1)));
        end
      end
      // occasional single-character corruption anywhere in the body
      if ($urandom_range(0, 9) == 0)
        line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      line_buf.push_back(CH_SEMI);
    end else if (r < 85) begin
      line_buf.push_back(cmd_letter[$urandom_range(0, 4)]);
      n = $urandom_range(0, 30);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: line_buf.push_back(rand_hex_char());
          5, 6:          line_buf.push_back(CH_COMMA);
          7:             line_buf.push_back(pin_letter[$urandom_range(0, 5)]);
          default:       line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      if ($urandom_range(0, 4) != 0) line_buf.push_back(CH_SEMI);
    end else begin
      repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic result_t pin_res(input logic [2:0] k, input int s, input logic [2:0] p,
                                      input int chan, input int dty, input bit lv);
    result_t r;
    r = '0;
    r.kind = k;
    r.slot = 4'(s);
    r.pin_kind = p;
    r.pwm_channel = 4'(chan);
    r.duty = 7'(dty);
    r.level = lv;
    return r;
  endfunction

  function automatic result_t can_res(input logic [11:0] id, input int cnt,
                                      input logic [63:0] pay);
    result_t r;
    r = '0;
    r.kind = KIND_CAN;
    r.can_id = id;
    r.can_count = 4'(cnt);
    r.can_payload = pay;
    return r;
  endfunction

  task automatic add_row(input string s, input bit typed, input bit has, input result_t r);
    dir_text.push_back(s);
    dir_typed.push_back(typed);
    dir_has.push_back(has);
    dir_res.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= !(idle_en && $urandom_range(0, 99) < 31);
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("serial_command_line_decoder_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int line_no;

    // Directed table: text, typed expectation?, result expected?, expectation
    add_row("x;\377z", 1, 0, '0);                              // idle noise ignored
    add_row("a0a;", 1, 1, pin_res(KIND_AREAD, 0, PIN_A, 0, 0, 0));
    add_row("d9q;", 1, 1, pin_res(KIND_DREAD, 9, PIN_Q, 0, 0, 0));
    add_row("b0a000;", 1, 1, pin_res(KIND_AWRITE, 0, PIN_A, 0, 0, 0));
    add_row("b9q899;", 1, 1, pin_res(KIND_AWRITE, 9, PIN_Q, 8, 99, 0));
    add_row("e5p1;", 1, 1, pin_res(KIND_DWRITE, 5, PIN_P, 0, 0, 1));
    add_row("e7e0;", 0, 0, '0);
    add_row("a3b;", 0, 0, '0);
    add_row("d4d;", 0, 0, '0);
    add_row("mFFF;", 1, 1, can_res(12'hFFF, 0, 64'h0));
    add_row("m000,00,11,22,33,44,55,66,ff;", 1, 1,
            can_res(12'h000, 8, 64'hff66554433221100));
    add_row("mAbC,De,f0;", 0, 0, '0);                         // mixed-case hex
    add_row("m1a2,bd;", 0, 0, '0);                            // command letters as body
    add_row("b1a900;", 1, 0, '0);                             // channel out of range
    add_row("a0c;", 1, 0, '0);                                // bad pin letter
    add_row("ax0;", 1, 0, '0);                                // slot not a digit
    add_row("a0a0;", 1, 0, '0);                               // body too long
    add_row("a0abc;a1b;", 1, 1, pin_res(KIND_AREAD, 1, PIN_B, 0, 0, 0)); // overflow, then ok
    add_row("e2d2;", 1, 0, '0);                               // level not 0/1
    add_row("e8q1b;", 1, 0, '0);                              // limit plus one stored
    add_row("dme;", 1, 0, '0);
    add_row("mfg0;", 1, 0, '0);                               // bad hex digit
    add_row("m123,4;", 1, 0, '0);                             // length not 3k
    add_row("m000,11,22,33,44,55,66,77,88,;", 1, 0, '0);      // 28 chars
    add_row("m000,11,22,33,44,55,66,77,88,99;", 1, 0, '0);    // CAN overflow
    add_row("a;", 1, 0, '0);                                  // empty body

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_char(8'h00);
    for (int i = 0; i < dir_text.size(); i++) begin
      // flag changes on a falling edge, clear of the previous row's last beat
      @(negedge clk);
      in_valid <= 1'b0;
      typed_row = dir_typed[i];
      if (dir_typed[i] && dir_has[i]) pending_cmds.push_back(dir_res[i]);
      for (int j = 0; j < dir_text[i].len(); j++) send_char(dir_text[i][j]);
    end
    drain_results();
    typed_row = 1'b0;

    // Random part
    line_no = 0;
    while (items_taken < N_ITEMS) begin
      if (line_no == 20) hold_req = 1'b1;     // receiver stalls, DUT backs up
      if (line_no == 60) idle_en = 1'b0;      // stretch at full rate
      if (line_no == 130) idle_en = 1'b1;
      if (line_no == 160) drain_results();    // sender pause until all out
      make_line();
      foreach (line_buf[j]) send_char(line_buf[j]);
      line_no++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (n_err == 0 && pending_cmds.size() == 0) begin
      $display("serial_command_line_decoder_unit test passed");
    end else begin
      $display("serial_command_line_decoder_unit test failed");
    end
    $finish;
  end

endmodule
